@@ rtl/core/smds_pkg.sv @@
package smds_pkg;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_EQ    = 4'd5,
    OP_ZERO  = 4'd6,
    OP_DROP  = 4'd7,
    OP_DUP   = 4'd8,
    OP_SWAP  = 4'd9,
    OP_OVER  = 4'd10,
    OP_PICK  = 4'd11,
    OP_ROT   = 4'd12,
    OP_2SWAP = 4'd13,
    OP_DEPTH = 4'd14,
    OP_POP   = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_OVERFLOW = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_FEW      = 3'd3,
    ERR_DIVZERO  = 3'd4
  } err_t;

  // datapath commands
  typedef enum logic [3:0] {
    DC_NONE,
    DC_RD,      // read entry count-off into one of the operand registers
    DC_WR,      // write selected value to entry count-off
    DC_MULDIV,  // start iterative unit
    DC_CNT      // set count
  } dcmd_t;

  typedef enum logic [2:0] {
    WS_LIT, WS_ALU, WS_A, WS_B, WS_C, WS_D, WS_CNT
  } wsel_t;

  typedef struct packed {
    dcmd_t      cmd;
    logic [1:0] rd_dst;
    logic [2:0] off;
    wsel_t      wsel;
    logic [3:0] op;
    logic       cnt_set;   // for DC_CNT: 0 clear, 1 apply delta
    logic signed [2:0] cnt_delta;
    logic       ld_pick;   // read offset from register a
    logic       tv_ld;     // load top value register from read data
    logic       lit_ld;    // capture literal at input transfer
  } ctl_t;

  typedef struct packed {
    logic       md_busy;
    logic       b_zero;
    logic       ab_eq;
    logic       a_zero;
  } sts_t;

endpackage

@@ rtl/core/smds_muldiv.sv @@
module smds_muldiv import smds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        busy,
  output logic [63:0] res
);

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        div_r, neg_r;
  logic [63:0] acc_r, q_r, d_r;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign busy = busy_r;
  assign rem_sh = {acc_r[62:0], q_r[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      neg_r <= a[63] ^ b[63];
      acc_r <= 64'd0;
      if (is_div) begin
        q_r <= a[63] ? (64'd0 - a) : a;
        d_r <= b[63] ? (64'd0 - b) : b;
      end else begin
        q_r <= a;
        d_r <= b;
      end
    end else if (busy_r) begin
      if (div_r) begin
        if (!trial[64]) begin
          acc_r <= trial[63:0];
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          acc_r <= rem_sh;
          q_r <= {q_r[62:0], 1'b0};
        end
      end else begin
        // shift-add from lsb of multiplier, low 64 bits only
        acc_r <= acc_r + (q_r[cnt_r[5:0]] ? (d_r << cnt_r[5:0]) : 64'd0);
      end
    end
  end

  always_comb begin
    if (div_r) res = neg_r ? (64'd0 - q_r) : q_r;
    else res = acc_r;
  end

endmodule

@@ rtl/core/smds_datapath.sv @@
module smds_datapath import smds_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_t          ctl,
  input  logic [63:0]   lit,
  output sts_t          sts,
  output logic [CW-1:0] count,
  output logic [63:0]   opa,
  output logic [63:0]   topv
);

  logic [63:0] mem [STACK_DEPTH];
  logic [CW-1:0] cnt_r;
  logic [63:0] a_r, b_r, c_r, d_r, rd_q, top_r, lit_r;
  logic [1:0] dst_r;
  logic rd_p0_r, tv_p0_r;
  logic [CW-1:0] raddr, waddr;
  logic [63:0] wdata, alu, md_res;
  logic md_busy;

  smds_muldiv u_md (
    .clk(clk), .rst_n(rst_n),
    .start(ctl.cmd == DC_MULDIV),
    .is_div(ctl.op == OP_DIV),
    .a(a_r), .b(b_r),
    .busy(md_busy), .res(md_res)
  );

  always_comb begin
    if (ctl.ld_pick) raddr = cnt_r - a_r[CW-1:0];
    else raddr = cnt_r - CW'(ctl.off);
    waddr = cnt_r - CW'(ctl.off);
    case (ctl.op)
      OP_ADD:  alu = a_r + b_r;
      OP_SUB:  alu = a_r - b_r;
      OP_EQ:   alu = (a_r == b_r) ? '1 : '0;
      OP_ZERO: alu = (a_r == 64'd0) ? '1 : '0;
      default: alu = md_res;
    endcase
    case (ctl.wsel)
      WS_LIT:  wdata = lit_r;
      WS_ALU:  wdata = alu;
      WS_A:    wdata = a_r;
      WS_B:    wdata = b_r;
      WS_C:    wdata = c_r;
      WS_D:    wdata = d_r;
      WS_CNT:  wdata = 64'(cnt_r);
      default: wdata = lit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == DC_WR) mem[waddr[AW-1:0]] <= wdata;
    if (ctl.lit_ld) lit_r <= lit;
    rd_q <= mem[raddr[AW-1:0]];
    dst_r <= ctl.rd_dst;
    if (rd_p0_r) begin
      case (dst_r)
        2'd0: a_r <= rd_q;
        2'd1: b_r <= rd_q;
        2'd2: c_r <= rd_q;
        default: d_r <= rd_q;
      endcase
    end
    if (tv_p0_r) top_r <= rd_q;
  end

  // read data is registered in rd_q, then written to the operand register named by the registered destination
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_p0_r <= 1'b0;
      tv_p0_r <= 1'b0;
    end else begin
      rd_p0_r <= (ctl.cmd == DC_RD);
      tv_p0_r <= ctl.tv_ld;
      if (ctl.cmd == DC_CNT) begin
        if (ctl.cnt_set) cnt_r <= cnt_r + CW'(signed'(ctl.cnt_delta));
        else cnt_r <= '0;
      end
    end
  end

  // controller waits in S_WAIT for the operand registers
  assign sts.md_busy = md_busy;
  assign sts.b_zero = (b_r == 64'd0);
  assign sts.ab_eq = (a_r == b_r);
  assign sts.a_zero = (a_r == 64'd0);
  assign count = cnt_r;
  assign opa = a_r;
  assign topv = top_r;

endmodule

@@ rtl/core/smds_ctrl.sv @@
module smds_ctrl import smds_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [3:0]    in_req_type,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [63:0]   out_top_value,
  output logic [6:0]    out_stack_depth,
  output logic [63:0]   out_popped_value,
  output logic          out_popped_valid,
  output logic [2:0]    out_error_code,
  output ctl_t          ctl,
  input  sts_t          sts,
  input  logic [CW-1:0] count,
  input  logic [63:0]   opa,
  input  logic [63:0]   topv
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_EXEC, S_MD, S_WB, S_TOP, S_TW, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] wait_r, wait_nxt;
  err_t err_r, err_nxt;
  logic [63:0] pop_r, pop_nxt;
  logic pv_r, pv_nxt;
  logic ov_r, ov_nxt;
  logic [CW-1:0] c_r, c_nxt;
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_stack_depth = 7'(count);
  assign out_popped_value = pop_r;
  assign out_popped_valid = pv_r;
  assign out_error_code = err_r;
  assign out_top_value = (count == '0) ? 64'd0 : topv;

  function automatic logic [2:0] nreads(op_t o);
    case (o)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_SWAP: nreads = 3'd2;
      OP_ZERO, OP_DUP, OP_PICK, OP_POP: nreads = 3'd1;
      OP_OVER: nreads = 3'd2;
      OP_ROT: nreads = 3'd3;
      OP_2SWAP: nreads = 3'd4;
      default: nreads = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] need(op_t o);
    case (o)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_SWAP, OP_OVER: need = 3'd2;
      OP_ZERO, OP_DUP: need = 3'd1;
      OP_ROT: need = 3'd3;
      OP_2SWAP: need = 3'd4;
      default: need = 3'd0;
    endcase
  endfunction

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    step_nxt = step_r;
    wait_nxt = wait_r;
    err_nxt = err_r;
    pop_nxt = pop_r;
    pv_nxt = pv_r;
    ov_nxt = ov_r;
    c_nxt = c_r;
    ctl = '0;
    ctl.cmd = DC_NONE;
    ctl.wsel = WS_LIT;
    ctl.op = op_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          ctl.lit_ld = 1'b1;
          op_nxt = op_t'(in_req_type);
          err_nxt = ERR_OK;
          pv_nxt = 1'b0;
          pop_nxt = 64'd0;
          step_nxt = 3'd0;
          c_nxt = count;
          if (CW'(need(op_t'(in_req_type))) > count) begin
            err_nxt = ERR_FEW;
            state_nxt = S_WB;
          end else if (op_t'(in_req_type) == OP_DROP || op_t'(in_req_type) == OP_PICK)
          begin
            if (count == '0) begin
              err_nxt = ERR_UNDERFLOW;
              state_nxt = S_WB;
            end else state_nxt = S_RD;
          end else if (op_t'(in_req_type) == OP_POP && count == '0) begin
            state_nxt = S_TOP;
          end else state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (step_r < nreads(op_r)) begin
          ctl.cmd = DC_RD;
          ctl.off = step_r + 3'd1;
          ctl.rd_dst = (op_r == OP_OVER) ? 2'(3'd1 - step_r) : 2'(step_r);
          // a=top first for unary; for binary a=second, b=top
          if (nreads(op_r) == 3'd2 && op_r != OP_OVER) ctl.rd_dst = 2'(3'd1 - step_r);
          step_nxt = step_r + 3'd1;
        end else begin
          wait_nxt = 3'd3;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (wait_r == 3'd0) begin
          state_nxt = S_EXEC;
          step_nxt = 3'd0;
        end else wait_nxt = wait_r - 3'd1;
      end
      S_EXEC: begin
        step_nxt = step_r + 3'd1;
        case (op_r)
          OP_PUSH, OP_DUP, OP_OVER, OP_DEPTH: begin
            if (count == FULL) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              ctl.cmd = DC_WR;
              ctl.off = 3'd0;
              ctl.wsel = (op_r == OP_PUSH) ? WS_LIT : (op_r == OP_DEPTH) ? WS_CNT :
                         (op_r == OP_DUP) ? WS_A : WS_A;
              c_nxt = count + CW'(1);
            end
            state_nxt = S_WB;
          end
          OP_ADD, OP_SUB, OP_EQ: begin
            ctl.cmd = DC_WR; ctl.off = 3'd2; ctl.wsel = WS_ALU;
            c_nxt = count - CW'(1);
            state_nxt = S_WB;
          end
          OP_MUL, OP_DIV: begin
            if (op_r == OP_DIV && sts.b_zero) begin
              err_nxt = ERR_DIVZERO;
              state_nxt = S_WB;
            end else begin
              ctl.cmd = DC_MULDIV;
              state_nxt = S_MD;
            end
          end
          OP_ZERO: begin
            ctl.cmd = DC_WR; ctl.off = 3'd1; ctl.wsel = WS_ALU;
            state_nxt = S_WB;
          end
          OP_DROP: begin
            c_nxt = count - CW'(1);
            state_nxt = S_WB;
          end
          OP_POP: begin
            pop_nxt = opa; pv_nxt = 1'b1;
            c_nxt = count - CW'(1);
            state_nxt = S_WB;
          end
          OP_SWAP: begin
            ctl.cmd = DC_WR;
            ctl.off = step_r[0] ? 3'd2 : 3'd1;
            ctl.wsel = step_r[0] ? WS_B : WS_A;
            if (step_r[0]) state_nxt = S_WB;
          end
          OP_ROT: begin
            // a=top,b=second,c=third
            ctl.cmd = DC_WR;
            case (step_r)
              3'd0: begin ctl.off = 3'd3; ctl.wsel = WS_B; end
              3'd1: begin ctl.off = 3'd2; ctl.wsel = WS_A; end
              default: begin ctl.off = 3'd1; ctl.wsel = WS_C; state_nxt = S_WB; end
            endcase
          end
          OP_2SWAP: begin
            ctl.cmd = DC_WR;
            case (step_r)
              3'd0: begin ctl.off = 3'd4; ctl.wsel = WS_B; end
              3'd1: begin ctl.off = 3'd3; ctl.wsel = WS_A; end
              3'd2: begin ctl.off = 3'd2; ctl.wsel = WS_D; end
              default: begin ctl.off = 3'd1; ctl.wsel = WS_C; state_nxt = S_WB; end
            endcase
          end
          OP_PICK: begin
            // a holds index; count is first decremented to drop it
            if (step_r == 3'd0) begin
              if (opa[63] || opa == 64'd0 || opa > 64'(count - CW'(1))) begin
                err_nxt = ERR_FEW;
                state_nxt = S_WB;
              end else begin
                ctl.cmd = DC_CNT; ctl.cnt_set = 1'b1; ctl.cnt_delta = -3'sd1;
              end
            end else if (step_r == 3'd1) begin
              ctl.cmd = DC_NONE;
            end else begin
              state_nxt = S_TW;
              wait_nxt = 3'd0;
            end
          end
          default: state_nxt = S_WB;
        endcase
      end
      S_MD: begin
        if (!sts.md_busy) begin
          ctl.cmd = DC_WR; ctl.off = 3'd2; ctl.wsel = WS_ALU;
          c_nxt = count - CW'(1);
          state_nxt = S_WB;
        end
      end
      S_TW: begin
        // pick read addressed by the index in a
        case (wait_r)
          3'd0: begin ctl.cmd = DC_RD; ctl.ld_pick = 1'b1; ctl.rd_dst = 2'd2;
                      wait_nxt = 3'd1; end
          3'd1, 3'd2, 3'd3: wait_nxt = wait_r + 3'd1;
          default: begin
            if (count == FULL) err_nxt = ERR_OVERFLOW;
            else begin
              ctl.cmd = DC_WR; ctl.off = 3'd0; ctl.wsel = WS_C;
              c_nxt = count + CW'(1);
            end
            state_nxt = S_WB;
          end
        endcase
      end
      S_WB: begin
        ctl.cmd = DC_CNT;
        ctl.cnt_set = (err_r == ERR_OK);
        ctl.cnt_delta = 3'(c_r - count);
        state_nxt = S_TOP;
        wait_nxt = 3'd0;
      end
      S_TOP: begin
        case (wait_r)
          3'd0: begin ctl.off = 3'd1; ctl.tv_ld = 1'b1; wait_nxt = 3'd1; end
          3'd1, 3'd2: wait_nxt = wait_r + 3'd1;
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      err_r <= ERR_OK;
      pv_r <= 1'b0;
      op_r <= OP_PUSH;
      step_r <= '0;
      wait_r <= '0;
      c_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      err_r <= err_nxt;
      pv_r <= pv_nxt;
      op_r <= op_nxt;
      step_r <= step_nxt;
      wait_r <= wait_nxt;
      c_r <= c_nxt;
    end
    pop_r <= pop_nxt;
  end

endmodule

@@ rtl/core/stack_machine_data_stack_alu_top.sv @@
// one item at a time; the next input transfer is taken the cycle after
// the result transfer
// multiply and divide use a 64-step shared shift unit
// reset: synchronous active-low rst_n empties the stack; stack memory is not cleared
module stack_machine_data_stack_alu_top import smds_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_req_type,
  input  logic signed [63:0] in_literal_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [63:0] out_top_value,
  output logic [6:0]  out_stack_depth,
  output logic signed [63:0] out_popped_value,
  output logic        out_popped_valid,
  output logic [2:0]  out_error_code
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  ctl_t ctl;
  sts_t sts;
  logic [CW-1:0] count;
  logic [63:0] opa, topv;
  logic [6:0] depth_w;

  smds_datapath #(.STACK_DEPTH(STACK_DEPTH), .AW(AW), .CW(CW)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .lit(in_literal_value), .sts(sts),
    .count(count), .opa(opa), .topv(topv)
  );

  smds_ctrl #(.STACK_DEPTH(STACK_DEPTH), .CW(CW)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_top_value(out_top_value), .out_stack_depth(depth_w),
    .out_popped_value(out_popped_value), .out_popped_valid(out_popped_valid),
    .out_error_code(out_error_code),
    .ctl(ctl), .sts(sts), .count(count), .opa(opa), .topv(topv)
  );

  assign out_stack_depth = depth_w;

endmodule

@@ verif/stack_machine_data_stack_alu_top_test.sv @@
module stack_machine_data_stack_alu_top_test;
  import smds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int LIMIT = 20000;
  localparam int N_RANDOM = 1300;

  typedef struct packed {
    op_t         op;
    logic [63:0] lit;
  } req_t;

  typedef struct packed {
    logic [63:0] top;
    logic [6:0]  depth;
    logic [63:0] popped;
    logic        pvalid;
    err_t        err;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_req_type = '0;
  logic signed [63:0] in_literal_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [63:0] out_top_value;
  logic [6:0]  out_stack_depth;
  logic signed [63:0] out_popped_value;
  logic        out_popped_valid;
  logic [2:0]  out_error_code;

  stack_machine_data_stack_alu_top u_top (.*);

  always #5 clk = ~clk;

  req_t        pending_reqs[$];
  resp_t       expected_resps[$];
  logic [63:0] model_stack[DEPTH];
  int          model_count;
  int          errors;
  int          phase;
  int          idle_cycles;
  bit          hold_sender;

  function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic err_t stack_push(logic [63:0] v);
    if (model_count >= DEPTH) begin
      model_count = 0;
      return ERR_OVERFLOW;
    end
    model_stack[model_count] = v;
    model_count++;
    return ERR_OK;
  endfunction

  function automatic resp_t predict_stack(req_t r);
    resp_t       o;
    err_t        e;
    int          c;
    logic [63:0] a, b, t;
    e = ERR_OK;
    c = model_count;
    o = '0;
    case (r.op)
      OP_PUSH: e = stack_push(r.lit);
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
        if (c < 2) e = ERR_FEW;
        else begin
          b = model_stack[c-1];
          a = model_stack[c-2];
          if (r.op == OP_DIV && b == 0) e = ERR_DIVZERO;
          else begin
            case (r.op)
              OP_ADD: t = a + b;
              OP_SUB: t = a - b;
              OP_MUL: t = a * b;
              OP_DIV: t = sdiv(a, b);
              default: t = (a == b) ? '1 : '0;
            endcase
            model_stack[c-2] = t;
            model_count = c - 1;
          end
        end
      end
      OP_ZERO: begin
        if (c < 1) e = ERR_FEW;
        else model_stack[c-1] = (model_stack[c-1] == 0) ? '1 : '0;
      end
      OP_DROP: begin
        if (c < 1) e = ERR_UNDERFLOW;
        else model_count = c - 1;
      end
      OP_DUP: begin
        if (c < 1) e = ERR_FEW;
        else e = stack_push(model_stack[c-1]);
      end
      OP_SWAP: begin
        if (c < 2) e = ERR_FEW;
        else begin
          t = model_stack[c-1];
          model_stack[c-1] = model_stack[c-2];
          model_stack[c-2] = t;
        end
      end
      OP_OVER: begin
        if (c < 2) e = ERR_FEW;
        else e = stack_push(model_stack[c-2]);
      end
      OP_PICK: begin
        if (c < 1) e = ERR_UNDERFLOW;
        else begin
          t = model_stack[c-1];
          c = c - 1;
          model_count = c;
          if (t[63] || t < 1 || t > c) e = ERR_FEW;
          else e = stack_push(model_stack[c - int'(t)]);
        end
      end
      OP_ROT: begin
        if (c < 3) e = ERR_FEW;
        else begin
          t = model_stack[c-3];
          model_stack[c-3] = model_stack[c-2];
          model_stack[c-2] = model_stack[c-1];
          model_stack[c-1] = t;
        end
      end
      OP_2SWAP: begin
        if (c < 4) e = ERR_FEW;
        else begin
          a = model_stack[c-4];
          b = model_stack[c-3];
          model_stack[c-4] = model_stack[c-2];
          model_stack[c-3] = model_stack[c-1];
          model_stack[c-2] = a;
          model_stack[c-1] = b;
        end
      end
      OP_DEPTH: e = stack_push(64'(c));
      default: begin
        if (c >= 1) begin
          o.popped = model_stack[c-1];
          o.pvalid = 1'b1;
          model_count = c - 1;
        end
      end
    endcase
    if (e != ERR_OK) model_count = 0;
    o.top = (model_count > 0) ? model_stack[model_count-1] : '0;
    o.depth = 7'(model_count);
    o.err = e;
    return o;
  endfunction

  task automatic queue_req(op_t op, logic [63:0] lit = '0);
    req_t r;
    r.op = op;
    r.lit = lit;
    pending_reqs.push_back(r);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = '1;
      3: v = '0;
      4: v = 64'($urandom_range(0, 8));
      5: v = -64'($urandom_range(1, 8));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    req_t r;
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && !hold_sender &&
            !(phase == 0 && $urandom_range(0, 99) < 13) &&
            !(phase == 1 && $urandom_range(0, 99) < 46)) begin
          r = pending_reqs.pop_front();
          expected_resps.push_back(predict_stack(r));
          in_valid <= 1'b1;
          in_req_type <= r.op;
          in_literal_value <= r.lit;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= (phase == 0) ? ($urandom_range(0, 99) < 46) :
                   (phase == 1) ? ($urandom_range(0, 99) < 13) : 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t w;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected transfer", '0, '0);
        end else begin
          w = expected_resps.pop_front();
          if (out_top_value !== w.top) report_mismatch("top", out_top_value, w.top);
          if (out_stack_depth !== w.depth)
            report_mismatch("depth", 64'(out_stack_depth), 64'(w.depth));
          if (out_popped_value !== w.popped)
            report_mismatch("popped", out_popped_value, w.popped);
          if (out_popped_valid !== w.pvalid)
            report_mismatch("popped_valid", 64'(out_popped_valid), 64'(w.pvalid));
          if (out_error_code !== w.err)
            report_mismatch("error", 64'(out_error_code), 64'(w.err));
        end
      end
      if (idle_cycles >= LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic fill_random(int n);
    int k, len;
    op_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        queue_req(OP_PUSH, rand64());
      end else if (k < 45) begin
        // pick with an index from -2 to 12
        queue_req(OP_PUSH, 64'($urandom_range(0, 12)) - 64'($urandom_range(0, 2)));
        queue_req(OP_PICK);
        i++;
      end else if (k < 47) begin
        // fill towards overflow
        len = $urandom_range(60, 66);
        for (int j = 0; j < len; j++) queue_req(OP_PUSH, rand64());
        queue_req(op_t'($urandom_range(0, 1) ? OP_DEPTH : OP_DUP));
        i += len;
      end else begin
        op = op_t'($urandom_range(1, 15));
        queue_req(op, {$urandom, $urandom});
      end
    end
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    errors = 0;
    phase = 0;
    idle_cycles = 0;
    hold_sender = 1'b0;
    model_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    queue_req(OP_DROP);
    queue_req(OP_POP);
    queue_req(OP_DUP);
    queue_req(OP_PICK);
    queue_req(OP_PUSH, 64'h8000_0000_0000_0000);
    queue_req(OP_PUSH, '1);
    queue_req(OP_DIV);
    queue_req(OP_PUSH, 64'h7fff_ffff_ffff_ffff);
    queue_req(OP_PUSH, 64'd1);
    queue_req(OP_ADD);
    queue_req(OP_PUSH, 64'd3);
    queue_req(OP_MUL);
    queue_req(OP_PUSH, 64'd0);
    queue_req(OP_DIV);
    queue_req(OP_PUSH, 64'd5);
    queue_req(OP_PUSH, 64'd9);
    queue_req(OP_SUB);
    queue_req(OP_ZERO);
    queue_req(OP_DEPTH);
    queue_req(OP_EQ);
    queue_req(OP_OVER);
    queue_req(OP_SWAP);
    queue_req(OP_ROT);
    queue_req(OP_2SWAP);
    queue_req(OP_POP);
    drain();
    // sender held back until all results are in
    hold_sender = 1'b1;
    fill_random(20);
    drain_results: wait (expected_resps.size() == 0);
    hold_sender = 1'b0;

    fill_random(N_RANDOM / 3);
    drain();
    phase = 1;
    fill_random(N_RANDOM / 3);
    drain();
    phase = 2;
    fill_random(N_RANDOM / 3);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ stack_machine_data_stack_alu_top.f @@
rtl/core/smds_pkg.sv
rtl/core/smds_muldiv.sv
rtl/core/smds_datapath.sv
rtl/core/smds_ctrl.sv
rtl/core/stack_machine_data_stack_alu_top.sv
verif/stack_machine_data_stack_alu_top_test.sv
